>>> design/mrf_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU master framer package
// Shared constants, the queue entry type and the byte-wise CRC-16 step.
// ----------------------------------------------------------------------------
package mrf_pkg;

	// Request frame length and how many leading bytes the CRC covers.
	localparam int REQ_LEN   = 8;
	localparam int CRC_BYTES = REQ_LEN - 2;
	localparam int TX_CNT_W  = $clog2(REQ_LEN);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Input item types.
	localparam logic REQ_SEND = 1'b0;
	localparam logic REQ_RECV = 1'b1;

	// Result kinds.
	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One queued job: a request to serialize or a finished frame report.
	typedef struct packed {
		logic        kind;
		logic        crc_ok;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [15:0] wa;
		logic [15:0] wb;
		logic [15:0] wc;
	} qent_t;

	// CRC-16/Modbus over one byte, reflected, one bit per step.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> design/mrf_front.sv
// ----------------------------------------------------------------------------
// Modbus RTU framer front end
// Accepts input beats, tracks the response frame and queues jobs for the back.
// ----------------------------------------------------------------------------
module mrf_front #(
	parameter int RESP_LEN = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	input  logic [7:0]    slave_addr,
	input  logic [7:0]    function_code,
	input  logic [15:0]   register_addr,
	input  logic [15:0]   data_word,
	input  logic [7:0]    rx_byte,
	input  logic          frame_start,
	input  logic          q_full,
	output logic          push,
	output mrf_pkg::qent_t push_ent
);

	localparam int CW        = $clog2(RESP_LEN + 1);
	localparam int FIRST_CAP = 3;
	localparam int NCAP      = 6;

	logic [CW-1:0] cnt_q;
	logic [15:0]   crc_q;
	logic [7:0]    byte0_q;
	logic [7:0]    crc_lo_q;
	logic [7:0]    cap_q [NCAP];

	logic          accept;
	logic          rx_take;
	logic [CW-1:0] idx;
	logic [CW-1:0] cnt_inc;
	logic [15:0]   crc_base;
	logic [15:0]   crc_upd;
	logic          frame_end;
	logic          crc_ok;
	logic [7:0]    cap_nx [NCAP];
	logic [7:0]    byte_v [NCAP];

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign rx_take  = accept && (req_type == mrf_pkg::REQ_RECV);

	always_comb begin
		idx       = (frame_start || (cnt_q >= CW'(RESP_LEN))) ? '0 : cnt_q;
		crc_base  = (idx == '0) ? mrf_pkg::CRC_INIT : crc_q;
		crc_upd   = (idx < CW'(RESP_LEN - 2)) ? mrf_pkg::crc_byte(crc_base, rx_byte) : crc_base;
		cnt_inc   = idx + 1'b1;
		frame_end = (cnt_inc == CW'(RESP_LEN));
		crc_ok    = ({rx_byte, crc_lo_q} == crc_upd);
		for (int i = 0; i < NCAP; i++) begin
			// Bytes past the end of a short frame never get written and read as zero.
			if ((FIRST_CAP + i < RESP_LEN) && (idx == CW'(FIRST_CAP + i))) begin
				cap_nx[i] = rx_byte;
			end else begin
				cap_nx[i] = cap_q[i];
			end
			byte_v[i] = (FIRST_CAP + i < RESP_LEN) ? cap_nx[i] : 8'h00;
		end
	end

	always_comb begin
		push = accept && ((req_type == mrf_pkg::REQ_SEND) || frame_end);
		if (req_type == mrf_pkg::REQ_SEND) begin
			push_ent.kind   = mrf_pkg::KIND_TX;
			push_ent.crc_ok = 1'b0;
			push_ent.b0     = slave_addr;
			push_ent.b1     = function_code;
			push_ent.wa     = register_addr;
			push_ent.wb     = data_word;
			push_ent.wc     = 16'h0000;
		end else begin
			push_ent.kind   = mrf_pkg::KIND_REPORT;
			push_ent.crc_ok = crc_ok;
			push_ent.b0     = byte0_q;
			push_ent.b1     = 8'h00;
			push_ent.wa     = {byte_v[0], byte_v[1]};
			push_ent.wb     = {byte_v[2], byte_v[3]};
			push_ent.wc     = {byte_v[4], byte_v[5]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= mrf_pkg::CRC_INIT;
		end else if (rx_take) begin
			cnt_q <= frame_end ? '0 : cnt_inc;
			crc_q <= frame_end ? mrf_pkg::CRC_INIT : crc_upd;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			if (idx == '0) begin
				byte0_q <= rx_byte;
			end
			if (idx == CW'(RESP_LEN - 2)) begin
				crc_lo_q <= rx_byte;
			end
			for (int i = 0; i < NCAP; i++) begin
				cap_q[i] <= cap_nx[i];
			end
		end
	end

	// The byte count is cleared on the final byte, so it never reaches the frame length.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(RESP_LEN))
		else $error("receive count reached the frame length");

endmodule

>>> design/mrf_queue.sv
// ----------------------------------------------------------------------------
// Modbus RTU framer job queue
// Small FIFO that decouples the front end from the byte serializer.
// ----------------------------------------------------------------------------
module mrf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrf_pkg::qent_t push_ent,
	output logic           full,
	input  logic           pop,
	output mrf_pkg::qent_t head,
	output logic           head_valid
);

	mrf_pkg::qent_t                mem_q [mrf_pkg::QUEUE_DEPTH];
	logic [mrf_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mrf_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mrf_pkg::QPTR_W:0]      count_q;

	assign full       = (count_q == (mrf_pkg::QPTR_W + 1)'(mrf_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ent;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue read while empty");

endmodule

>>> design/mrf_back.sv
// ----------------------------------------------------------------------------
// Modbus RTU framer back end
// Serializes request jobs into eight bytes with CRC and issues frame reports.
// ----------------------------------------------------------------------------
module mrf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  mrf_pkg::qent_t head,
	input  logic           head_valid,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           out_kind,
	output logic [7:0]     tx_byte,
	output logic           last,
	output logic           crc_ok,
	output logic [7:0]     resp_slave,
	output logic [15:0]    word_a,
	output logic [15:0]    word_b,
	output logic [15:0]    word_c
);

	localparam logic [mrf_pkg::TX_CNT_W-1:0] LAST_POS =
		mrf_pkg::TX_CNT_W'(mrf_pkg::REQ_LEN - 1);
	localparam logic [mrf_pkg::TX_CNT_W-1:0] CRC_END =
		mrf_pkg::TX_CNT_W'(mrf_pkg::CRC_BYTES);

	logic                          out_valid_q;
	logic [mrf_pkg::TX_CNT_W-1:0]  tx_cnt_q;
	logic [15:0]                   crc_q;
	logic                          kind_q;
	logic [7:0]                    tx_byte_q;
	logic                          last_q;
	logic                          crc_ok_q;
	logic [7:0]                    slave_q;
	logic [15:0]                   word_a_q;
	logic [15:0]                   word_b_q;
	logic [15:0]                   word_c_q;

	logic       load;
	logic       is_tx;
	logic       tx_last;
	logic [7:0] byte_sel;

	assign load    = head_valid && (!out_valid_q || out_ready);
	assign is_tx   = (head.kind == mrf_pkg::KIND_TX);
	assign tx_last = (tx_cnt_q == LAST_POS);
	assign pop     = load && (!is_tx || tx_last);

	always_comb begin
		case (tx_cnt_q)
			3'd0:    byte_sel = head.b0;
			3'd1:    byte_sel = head.b1;
			3'd2:    byte_sel = head.wa[15:8];
			3'd3:    byte_sel = head.wa[7:0];
			3'd4:    byte_sel = head.wb[15:8];
			3'd5:    byte_sel = head.wb[7:0];
			3'd6:    byte_sel = crc_q[7:0];
			default: byte_sel = crc_q[15:8];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tx_cnt_q    <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && is_tx) begin
				tx_cnt_q <= tx_last ? '0 : tx_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (is_tx) begin
				kind_q    <= mrf_pkg::KIND_TX;
				tx_byte_q <= byte_sel;
				last_q    <= tx_last;
				crc_ok_q  <= 1'b0;
				slave_q   <= 8'h00;
				word_a_q  <= 16'h0000;
				word_b_q  <= 16'h0000;
				word_c_q  <= 16'h0000;
				if (tx_cnt_q < CRC_END) begin
					crc_q <= mrf_pkg::crc_byte((tx_cnt_q == '0) ? mrf_pkg::CRC_INIT : crc_q,
						byte_sel);
				end
			end else begin
				kind_q    <= mrf_pkg::KIND_REPORT;
				tx_byte_q <= 8'h00;
				last_q    <= 1'b0;
				crc_ok_q  <= head.crc_ok;
				slave_q   <= head.b0;
				word_a_q  <= head.wa;
				word_b_q  <= head.wb;
				word_c_q  <= head.wc;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = kind_q;
	assign tx_byte    = tx_byte_q;
	assign last       = last_q;
	assign crc_ok     = crc_ok_q;
	assign resp_slave = slave_q;
	assign word_a     = word_a_q;
	assign word_b     = word_b_q;
	assign word_c     = word_c_q;

	// In the middle of a frame the queue head must still be that request.
	a_mid_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_cnt_q != '0) |-> (head_valid && (head.kind == mrf_pkg::KIND_TX)))
		else $error("request frame lost its queue entry");

	// Once the final byte sits in the output register the byte counter has wrapped.
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q && (kind_q == mrf_pkg::KIND_TX)) |-> (tx_cnt_q == '0))
		else $error("byte counter did not wrap after the final byte");

endmodule

>>> design/modbus_rtu_master_framer.sv
// ----------------------------------------------------------------------------
// Modbus RTU master framer
// Builds request frames with CRC-16 and checks fixed-length response frames.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Beat carries
//   in        to block    in_valid / in_ready    request fields or one rx byte
//   out       from block  out_valid / out_ready  one tx byte or one frame report
//
// Back-to-back received bytes are taken every cycle while the job queue has
// room. A request becomes eight output beats, one per cycle while out_ready
// stays high; the serializer in the back end sets that pace, computing the
// CRC one byte per beat. A frame report leaves as a single beat. The first
// output beat of a job passes through the job queue, then the output register.
// Reset clears the receive count and CRC, the queue pointers and the output
// valid flag. Input and output stall independently through the four-entry
// job queue; in_ready drops only while that queue is full.
//
module modbus_rtu_master_framer #(
	parameter int RESP_LEN = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  slave_addr,
	input  logic [7:0]  function_code,
	input  logic [15:0] register_addr,
	input  logic [15:0] data_word,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic        crc_ok,
	output logic [7:0]  resp_slave,
	output logic [15:0] word_a,
	output logic [15:0] word_b,
	output logic [15:0] word_c
);

	// Jobs move from the front end to the queue, then from the queue head to the back.
	logic           push;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	mrf_pkg::qent_t push_ent;
	mrf_pkg::qent_t head;

	// The front end owns the response frame state: it counts bytes, runs the
	// CRC over the payload bytes and keeps just the bytes the report needs.
	mrf_front #(
		.RESP_LEN (RESP_LEN)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.slave_addr    (slave_addr),
		.function_code (function_code),
		.register_addr (register_addr),
		.data_word     (data_word),
		.rx_byte       (rx_byte),
		.frame_start   (frame_start),
		.q_full        (q_full),
		.push          (push),
		.push_ent      (push_ent)
	);

	// The queue holds requests and finished reports in arrival order.
	mrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// The back end drains the queue head into the registered output stage.
	mrf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.tx_byte    (tx_byte),
		.last       (last),
		.crc_ok     (crc_ok),
		.resp_slave (resp_slave),
		.word_a     (word_a),
		.word_b     (word_b),
		.word_c     (word_c)
	);

endmodule

>>> verif/mrf_frame_checker.sv
// ----------------------------------------------------------------------------
// Modbus RTU master framer checker
// Watches both channels of the framer, predicts every output beat from the
// accepted input beats and compares each output beat with the oldest
// prediction still outstanding.
// ----------------------------------------------------------------------------
module mrf_frame_checker #(
	parameter int RESP_LEN = 13
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  slave_addr,
	input  logic [7:0]  function_code,
	input  logic [15:0] register_addr,
	input  logic [15:0] data_word,
	input  logic [7:0]  rx_byte,
	input  logic        frame_start,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        out_kind,
	input  logic [7:0]  tx_byte,
	input  logic        last,
	input  logic        crc_ok,
	input  logic [7:0]  resp_slave,
	input  logic [15:0] word_a,
	input  logic [15:0] word_b,
	input  logic [15:0] word_c,
	output int          fail_count,
	output int          n_waiting,
	output int          n_tx_beats,
	output int          n_reports,
	output int          n_good_reports
);

	localparam int SHOW_LIMIT = 10;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic        lst;
		logic        ok;
		logic [7:0]  slave;
		logic [15:0] wa;
		logic [15:0] wb;
		logic [15:0] wc;
	} beat_t;

	beat_t       expected_beats[$];
	logic [15:0] frame_crc;
	int          frame_pos;
	logic [7:0]  frame_bytes [RESP_LEN];
	int          errs;
	int          tx_seen;
	int          rep_seen;
	int          good_seen;

	// CRC-16/Modbus, one data bit folded in per step.
	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		logic        fb;
		r = acc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ data[i];
			r  = r >> 1;
			if (fb)
				r = r ^ mrf_pkg::CRC_POLY;
		end
		return r;
	endfunction

	// Bytes past the end of a short response read as zero.
	function automatic logic [7:0] frame_byte(input int idx);
		return (idx < RESP_LEN) ? frame_bytes[idx] : 8'h00;
	endfunction

	function automatic string show(input beat_t b);
		return $sformatf(
			"kind=%0d tx=%02h last=%0d crc_ok=%0d slave=%02h a=%04h b=%04h c=%04h",
			b.kind, b.tx, b.lst, b.ok, b.slave, b.wa, b.wb, b.wc);
	endfunction

	// A request turns into eight transmit beats: six header bytes, then the CRC low byte first.
	task automatic queue_request_bytes();
		logic [7:0]  req [mrf_pkg::REQ_LEN];
		logic [15:0] crc;
		beat_t       b;
		req[0] = slave_addr;
		req[1] = function_code;
		req[2] = register_addr[15:8];
		req[3] = register_addr[7:0];
		req[4] = data_word[15:8];
		req[5] = data_word[7:0];
		crc = mrf_pkg::CRC_INIT;
		for (int k = 0; k < mrf_pkg::CRC_BYTES; k++)
			crc = crc16_step(crc, req[k]);
		req[mrf_pkg::REQ_LEN - 2] = crc[7:0];
		req[mrf_pkg::REQ_LEN - 1] = crc[15:8];
		for (int k = 0; k < mrf_pkg::REQ_LEN; k++) begin
			b      = '0;
			b.kind = mrf_pkg::KIND_TX;
			b.tx   = req[k];
			b.lst  = (k == mrf_pkg::REQ_LEN - 1);
			expected_beats.push_back(b);
		end
	endtask

	// One received byte; the frame's final byte yields a report.
	task automatic absorb_rx_byte();
		beat_t b;
		if (frame_start || frame_pos >= RESP_LEN) begin
			frame_pos = 0;
			frame_crc = mrf_pkg::CRC_INIT;
		end
		frame_bytes[frame_pos] = rx_byte;
		if (frame_pos < RESP_LEN - 2)
			frame_crc = crc16_step(frame_crc, rx_byte);
		frame_pos++;
		if (frame_pos == RESP_LEN) begin
			b       = '0;
			b.kind  = mrf_pkg::KIND_REPORT;
			b.ok    = ({frame_bytes[RESP_LEN - 1], frame_bytes[RESP_LEN - 2]} == frame_crc);
			b.slave = frame_bytes[0];
			b.wa    = {frame_byte(3), frame_byte(4)};
			b.wb    = {frame_byte(5), frame_byte(6)};
			b.wc    = {frame_byte(7), frame_byte(8)};
			expected_beats.push_back(b);
			frame_pos = 0;
			frame_crc = mrf_pkg::CRC_INIT;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		beat_t seen;
		beat_t want;
		if (!arst_n) begin
			expected_beats.delete();
			frame_pos      = 0;
			frame_crc      = mrf_pkg::CRC_INIT;
			errs           = 0;
			tx_seen        = 0;
			rep_seen       = 0;
			good_seen      = 0;
			fail_count     <= 0;
			n_waiting      <= 0;
			n_tx_beats     <= 0;
			n_reports      <= 0;
			n_good_reports <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {out_kind, tx_byte, last, crc_ok, resp_slave, word_a, word_b, word_c};
				if (seen.kind == mrf_pkg::KIND_TX) begin
					tx_seen++;
				end else begin
					rep_seen++;
					if (seen.ok)
						good_seen++;
				end
				if (expected_beats.size() == 0) begin
					errs++;
					if (errs <= SHOW_LIMIT)
						$display("unexpected output beat: %s", show(seen));
				end else begin
					want = expected_beats.pop_front();
					if (seen !== want) begin
						errs++;
						if (errs <= SHOW_LIMIT)
							$display("output beat %0d: expected %s, got %s",
								tx_seen + rep_seen, show(want), show(seen));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (req_type == mrf_pkg::REQ_SEND)
					queue_request_bytes();
				else
					absorb_rx_byte();
			end
			fail_count     <= errs;
			n_waiting      <= expected_beats.size();
			n_tx_beats     <= tx_seen;
			n_reports      <= rep_seen;
			n_good_reports <= good_seen;
		end
	end

endmodule

>>> verif/tb_modbus_rtu_master_framer.sv
// ----------------------------------------------------------------------------
// Modbus RTU master framer testbench
// Drives request and receive beats into the framer under random idling on
// both channels and lets the checker compare every output beat.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_master_framer;

	localparam int RESP_LEN     = 13;
	// Random beats after the directed opening, spread over three idling phases.
	localparam int RAND_ITEMS   = 336;
	// Cycles with no beat on either channel before the run is declared hung.
	localparam int IDLE_LIMIT   = 5000;
	// Quiet time after the last expected beat; covers the path through the queue
	// and output register plus a full eight-byte request with margin.
	localparam int DRAIN_CYCLES = 16;

	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        req_type      = mrf_pkg::REQ_SEND;
	logic [7:0]  slave_addr    = '0;
	logic [7:0]  function_code = '0;
	logic [15:0] register_addr = '0;
	logic [15:0] data_word     = '0;
	logic [7:0]  rx_byte       = '0;
	logic        frame_start   = 1'b0;
	logic        out_ready     = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic        crc_ok;
	logic [7:0]  resp_slave;
	logic [15:0] word_a;
	logic [15:0] word_b;
	logic [15:0] word_c;

	int fail_count;
	int n_waiting;
	int n_tx_beats;
	int n_reports;
	int n_good_reports;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int n_items       = 0;
	int quiet_cycles  = 0;

	modbus_rtu_master_framer #(.RESP_LEN(RESP_LEN)) u_top (.*);

	mrf_frame_checker #(.RESP_LEN(RESP_LEN)) u_chk (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls at random; the stall rate follows the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hang detector: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("tb_modbus_rtu_master_framer: errors");
			$finish;
		end
	end

	// Field values lean on the extremes one time in four.
	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Presents one input beat and returns right after the edge that accepts it.
	// Random idle cycles come first, so valid only drops between beats and the
	// payload stays put while the beat waits for in_ready.
	task automatic drive_beat(input logic kind, input logic [7:0] sa, input logic [7:0] fc,
			input logic [15:0] ra, input logic [15:0] dw, input logic [7:0] rb,
			input logic fs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= kind;
		slave_addr    <= sa;
		function_code <= fc;
		register_addr <= ra;
		data_word     <= dw;
		rx_byte       <= rb;
		frame_start   <= fs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_items++;
	endtask

	// The fields a beat does not use still carry random junk, so the block
	// is shown to ignore them.
	task automatic send_request(input logic [7:0] sa, input logic [7:0] fc,
			input logic [15:0] ra, input logic [15:0] dw);
		drive_beat(mrf_pkg::REQ_SEND, sa, fc, ra, dw, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_rx(input logic [7:0] b, input logic fs);
		drive_beat(mrf_pkg::REQ_RECV, 8'($urandom), 8'($urandom), 16'($urandom),
			16'($urandom), b, fs);
	endtask

	task automatic send_random_request();
		logic [7:0] fc;
		case ($urandom_range(3))
			0: fc = FC_READ_HOLDING;
			1: fc = FC_WRITE_SINGLE;
			default: fc = pick_byte();
		endcase
		send_request(pick_byte(), fc, {pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});
	endtask

	// Sends the first n_bytes of a response frame that carries a valid CRC
	// unless corrupt is set, in which case one bit anywhere in the frame is
	// flipped. Only byte 0 may carry the start mark. A request can be slipped
	// in ahead of byte req_at to show that it leaves the reception alone.
	task automatic send_response(input int n_bytes, input logic marked, input logic corrupt,
			input int req_at);
		logic [7:0]  body [RESP_LEN];
		logic [15:0] crc;
		int          hit;
		crc = mrf_pkg::CRC_INIT;
		for (int k = 0; k < RESP_LEN - 2; k++) begin
			body[k] = pick_byte();
			crc     = mrf_pkg::crc_byte(crc, body[k]);
		end
		body[RESP_LEN - 2] = crc[7:0];
		body[RESP_LEN - 1] = crc[15:8];
		if (corrupt) begin
			hit       = int'($urandom_range(RESP_LEN - 1));
			body[hit] = body[hit] ^ (8'h01 << $urandom_range(7));
		end
		for (int k = 0; k < n_bytes; k++) begin
			if (k == req_at)
				send_random_request();
			send_rx(body[k], (k == 0) && marked);
		end
	endtask

	// Mostly whole, well-formed frames so that reports keep coming, with
	// requests, unmarked starts, cut-off frames and loose noise bytes mixed in.
	task automatic run_random(input int target);
		int first;
		int r;
		int req_at;
		logic bad;
		first = n_items;
		while (n_items - first < target) begin
			r      = int'($urandom_range(99));
			req_at = ($urandom_range(7) == 0) ? int'($urandom_range(RESP_LEN - 1)) : -1;
			bad    = ($urandom_range(4) == 0);
			if (r < 15) begin
				send_random_request();
			end else if (r < 70) begin
				send_response(RESP_LEN, 1'b1, bad, req_at);
			end else if (r < 80) begin
				// No start mark: only lines up if the last frame finished.
				send_response(RESP_LEN, 1'b0, bad, req_at);
			end else if (r < 90) begin
				// Cut short; the next marked byte has to throw this away.
				send_response(int'($urandom_range(1, RESP_LEN - 1)), 1'b1, 1'b0, req_at);
			end else begin
				repeat ($urandom_range(1, 4))
					send_rx(pick_byte(), 1'($urandom_range(1)));
			end
		end
	endtask

	// Holds the sender back until every predicted beat has come out. The first
	// edge lets the checker's count catch up with the beat just accepted.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_waiting != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Phase one: sender idles a third of the time, receiver more than half.
		send_idle_pct = 33;
		recv_idle_pct = 56;

		// Requests with every field at its floor and its ceiling, then a plain read.
		send_request(8'h00, 8'h00, 16'h0000, 16'h0000);
		send_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_request(8'h01, FC_READ_HOLDING, 16'h0100, 16'h0003);
		// A frame abandoned after two bytes, restarted by a fresh start mark,
		// with a request arriving in the middle of the reception.
		send_response(2, 1'b1, 1'b0, -1);
		send_response(RESP_LEN, 1'b1, 1'b0, 6);
		// Right after a report an unmarked byte still opens a new frame; this
		// one also has a damaged checksum.
		send_response(RESP_LEN, 1'b0, 1'b1, -1);

		run_random(RAND_ITEMS / 3);
		hold_until_drained();

		// Phase two: the idling rates swap sides.
		send_idle_pct = 56;
		recv_idle_pct = 33;
		run_random(RAND_ITEMS / 3);
		hold_until_drained();

		// Phase three: both sides at full rate.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d input beats; checked %0d transmit bytes and %0d frame reports",
			n_items, n_tx_beats, n_reports);
		$display("(%0d good CRC) under 33/56, 56/33 and 0/0 percent sender/receiver idling.",
			n_good_reports);
		if (fail_count == 0)
			$display("tb_modbus_rtu_master_framer: clean");
		else
			$display("tb_modbus_rtu_master_framer: errors");
		$finish;
	end

endmodule
